// ===== rtl/csw_pkg.sv =====
// ----------------------------------------------------------------------------
// csw_pkg: shared types and constants of the counting semaphore
// Sizes, command and status codes, and the decoded command between the
// front and the back end.
// ----------------------------------------------------------------------------
package csw_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int COUNT_BITS = 16;
    localparam int ID_BITS    = 8;
    localparam int PTR_BITS   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_BITS  = $clog2(WAIT_DEPTH + 1);

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;

    localparam int S_TDATA_BITS = ((ID_BITS + 7) / 8) * 8;
    localparam int M_PAYLOAD_BITS = ID_BITS + COUNT_BITS + FILL_BITS;
    localparam int M_TDATA_BITS = ((M_PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - M_PAYLOAD_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WAIT    = 2'd0,
        CMD_TRYWAIT = 2'd1,
        CMD_POST    = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_code_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GRANTED     = 3'd0,
        ST_PARKED      = 3'd1,
        ST_WOULDBLOCK  = 3'd2,
        ST_WOKE        = 3'd3,
        ST_INCREMENTED = 3'd4,
        ST_ERROR       = 3'd5
    } status_t;

    // Classified command: what the back end is allowed to do with it.
    typedef struct packed {
        logic               bad;       // unused code, report error only
        logic               post;      // release a unit or a waiter
        logic               may_park;  // blocking wait, queue when count is zero
        logic [ID_BITS-1:0] id;
    } csw_cmd_t;

endpackage

// ===== rtl/csw_front.sv =====
// ----------------------------------------------------------------------------
// csw_front: command intake
// Accept input beats, classify the command code and hold the result in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module csw_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [csw_pkg::CMD_BITS-1:0] s_cmd,
    input  logic [csw_pkg::ID_BITS-1:0]  s_id,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output csw_pkg::csw_cmd_t            cmd
);
    import csw_pkg::*;

    csw_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    csw_cmd_t   decoded;
    logic       push, pop;

    always_comb begin
        decoded = '0;
        decoded.id = s_id;
        unique case (cmd_code_t'(s_cmd))
            CMD_WAIT: begin
                decoded.may_park = 1'b1;
            end
            CMD_TRYWAIT: begin
                decoded.may_park = 1'b0;
            end
            CMD_POST: begin
                decoded.post = 1'b1;
            end
            default: begin
                decoded.bad = 1'b1;
            end
        endcase
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/csw_back.sv =====
// ----------------------------------------------------------------------------
// csw_back: semaphore execution
// Hold the count and the waiter ring, carry out one command per cycle while
// the output channel is not stalled, and register each result for that channel.
// ----------------------------------------------------------------------------
module csw_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [csw_pkg::COUNT_BITS-1:0]  cfg_count,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  csw_pkg::csw_cmd_t               cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [csw_pkg::STATUS_BITS-1:0] m_status,
    output logic [csw_pkg::ID_BITS-1:0]     m_woken_id,
    output logic [csw_pkg::COUNT_BITS-1:0]  m_count_after,
    output logic [csw_pkg::FILL_BITS-1:0]   m_waiters_after
);
    import csw_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0]   head_reg, head_next;
    logic [PTR_BITS-1:0]   tail_reg, tail_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic [ID_BITS-1:0]    ring_reg [WAIT_DEPTH];

    logic                  valid_reg;
    status_t               status_reg, status_next;
    logic [ID_BITS-1:0]    woken_reg, woken_next;

    logic take, push;

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] i);
        if (i == PTR_BITS'(WAIT_DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    assign cmd_ready = !valid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;

    always_comb begin
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        push        = 1'b0;
        status_next = ST_ERROR;
        woken_next  = '0;
        priority if (cmd.bad) begin
            status_next = ST_ERROR;
        end else if (cmd.post) begin
            if (fill_reg != '0) begin
                woken_next  = ring_reg[head_reg];
                head_next   = next_slot(head_reg);
                fill_next   = fill_reg - 1'b1;
                status_next = ST_WOKE;
            end else if (!(&count_reg)) begin
                count_next  = count_reg + 1'b1;
                status_next = ST_INCREMENTED;
            end
        end else if (count_reg != '0) begin
            count_next  = count_reg - 1'b1;
            status_next = ST_GRANTED;
        end else if (cmd.may_park) begin
            if (fill_reg != FILL_BITS'(WAIT_DEPTH)) begin
                push        = 1'b1;
                tail_next   = next_slot(tail_reg);
                fill_next   = fill_reg + 1'b1;
                status_next = ST_PARKED;
            end
        end else begin
            status_next = ST_WOULDBLOCK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_count;
                head_reg  <= '0;
                tail_reg  <= '0;
                fill_reg  <= '0;
            end else if (take) begin
                count_reg <= count_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
            end
            if (take) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: capture alongside the state update.
    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg <= status_next;
            woken_reg  <= woken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && push) begin
            ring_reg[tail_reg] <= cmd.id;
        end
    end

    assign m_tvalid        = valid_reg;
    assign m_status        = status_reg;
    assign m_woken_id      = woken_reg;
    assign m_count_after   = count_reg;
    assign m_waiters_after = fill_reg;

endmodule

// ===== rtl/counting_semaphore_wait_queue.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue: counting semaphore with a FIFO of waiters
// A command beat waits in the front-end queue; the back end then carries it
// out and registers its result beat. Throughput: one command per cycle,
// retired by the back end, while the result channel is not stalled.
// Reset (aresetn low, synchronous): count 0, waiter ring empty, no beats held.
// Writing the configuration channel loads the count and empties the ring.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: initial_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csw_pkg::COUNT_BITS-1:0]    cfg_data,
    // command channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [csw_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [7:0] thread_id
    input  logic [csw_pkg::CMD_BITS-1:0]      s_tuser,   // [1:0] cmd
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csw_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [7:0] woken_id,
                                                         // [23:8] count_after,
                                                         // [28:24] waiters_after
    output logic [csw_pkg::STATUS_BITS-1:0]   m_tuser    // [2:0] status
);
    import csw_pkg::*;

    logic                  cmd_valid;
    logic                  cmd_ready;
    csw_cmd_t              cmd;
    logic [ID_BITS-1:0]    woken_id;
    logic [COUNT_BITS-1:0] count_after;
    logic [FILL_BITS-1:0]  waiters_after;

    // User must issue config writes only while the block is idle; not enforced.
    assign cfg_ready = 1'b1;

    // Front end: classify each command beat and queue it.
    csw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_cmd     (s_tuser),
        .s_id      (s_tdata[ID_BITS-1:0]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: count, waiter ring and the registered result beat.
    csw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_count       (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_status        (m_tuser),
        .m_woken_id      (woken_id),
        .m_count_after   (count_after),
        .m_waiters_after (waiters_after)
    );

    // Pack result fields, lowest first; pad the top with zeros.
    assign m_tdata = {{M_PAD_BITS{1'b0}}, waiters_after, count_after, woken_id};

`ifndef NO_ASSERTIONS
    // A stalled command toward the back end must hold until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("queued command changed while stalled");

    // Threads only wait while the count is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (count_after != '0) |-> (waiters_after == '0))
        else $error("waiters present with a positive count");

    // A parked thread leaves the count at zero and the ring non-empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_PARKED) |-> (count_after == '0) && (waiters_after != '0))
        else $error("parked result with inconsistent state");

    // A post only increments when nobody waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_INCREMENTED) |-> (waiters_after == '0))
        else $error("count incremented while threads wait");
`endif

endmodule
